// ===== design/dlsr_pkg.sv =====
// Shared types and constants for the dynamic label segment reassembler.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dlsr_pkg;

    // Store geometry.
    localparam int SEG_SLOTS = 8;
    localparam int SEG_BYTES = 16;
    localparam int SLOT_W    = $clog2(SEG_SLOTS);
    localparam int CNT_W     = $clog2(SEG_SLOTS + 1);
    localparam int TEXT_W    = 8 * SEG_BYTES;
    localparam int LEN_W     = 5;

    // Prefix bit positions.
    localparam int TOGGLE_BIT = 7;
    localparam int FIRST_BIT  = 6;
    localparam int LAST_BIT   = 5;
    localparam int LEN_LSB    = 0;
    localparam int LEN_MSB    = 3;
    localparam int SEGNUM_LSB = 4;
    localparam int SEGNUM_MSB = 6;

    // Queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result status codes; also used as the command kind in the queue.
    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_DUPLICATE  = 2'd1,
        ST_EMIT       = 2'd2
    } t_status;

    // Back-end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // Command handed from the front to the back.
    typedef struct packed {
        t_status             kind;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    len;
        logic [TEXT_W-1:0]   text;
        logic [CNT_W-1:0]    count;
    } t_cmd;

endpackage

// ===== design/dlsr_front.sv =====
// Front end: accepts segments, decodes the prefix, tracks slot occupancy and
// decides whether each segment is a duplicate, an incomplete or a completing one.
// Depends on dlsr_pkg.
module dlsr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_prefix_first_byte,
    input  logic [7:0]           i_prefix_second_byte,
    input  logic [63:0]          i_chars_low,
    input  logic [63:0]          i_chars_high,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output dlsr_pkg::t_cmd       o_cmd
);

    logic [dlsr_pkg::SEG_SLOTS-1:0] r_present;
    logic [dlsr_pkg::SEG_SLOTS-1:0] r_is_last;
    logic                           r_toggle;
    logic [dlsr_pkg::SEG_SLOTS-1:0] n_present;
    logic [dlsr_pkg::SEG_SLOTS-1:0] n_is_last;
    logic                           n_toggle;

    logic                           accept;
    logic                           toggle;
    logic                           first;
    logic                           lastf;
    logic [dlsr_pkg::LEN_W-1:0]     len;
    logic [2:0]                     seg;
    logic [dlsr_pkg::SLOT_W-1:0]    slot;
    logic                           in_range;
    logic                           dup;
    logic [dlsr_pkg::SEG_SLOTS-1:0] eff_present;
    logic [dlsr_pkg::SEG_SLOTS-1:0] eff_last;
    logic [dlsr_pkg::SEG_SLOTS-1:0] upd_present;
    logic [dlsr_pkg::SEG_SLOTS-1:0] upd_last;
    logic                           complete;
    logic                           scan_done;
    logic [dlsr_pkg::CNT_W-1:0]     count;
    logic [dlsr_pkg::TEXT_W-1:0]    raw_text;
    logic [dlsr_pkg::TEXT_W-1:0]    masked_text;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // Prefix decode.
    assign toggle   = i_prefix_first_byte[dlsr_pkg::TOGGLE_BIT];
    assign first    = i_prefix_first_byte[dlsr_pkg::FIRST_BIT];
    assign lastf    = i_prefix_first_byte[dlsr_pkg::LAST_BIT];
    assign len      = dlsr_pkg::LEN_W'(i_prefix_first_byte[dlsr_pkg::LEN_MSB:dlsr_pkg::LEN_LSB])
                      + dlsr_pkg::LEN_W'(1);
    assign seg      = first ? 3'd0
                            : i_prefix_second_byte[dlsr_pkg::SEGNUM_MSB:dlsr_pkg::SEGNUM_LSB];
    assign slot     = seg[dlsr_pkg::SLOT_W-1:0];
    assign in_range = ({1'b0, seg} < 4'(dlsr_pkg::SEG_SLOTS));

    // A toggle change clears the store before the duplicate test.
    always_comb begin
        if ((r_present != '0) && (r_toggle != toggle)) begin
            eff_present = '0;
            eff_last    = '0;
        end else begin
            eff_present = r_present;
            eff_last    = r_is_last;
        end
    end

    assign dup = !in_range || eff_present[slot];

    // Store view after the segment has been added.
    always_comb begin
        upd_present       = eff_present;
        upd_last          = eff_last;
        upd_present[slot] = 1'b1;
        upd_last[slot]    = lastf;
    end

    // Look for a run of present slots from zero that ends in a last segment.
    always_comb begin
        complete  = 1'b0;
        scan_done = 1'b0;
        count     = '0;
        for (int i = 0; i < dlsr_pkg::SEG_SLOTS; i++) begin
            if (!scan_done) begin
                if (!upd_present[i]) begin
                    scan_done = 1'b1;
                end else begin
                    count = dlsr_pkg::CNT_W'(i + 1);
                    if (upd_last[i]) begin
                        complete  = 1'b1;
                        scan_done = 1'b1;
                    end
                end
            end
        end
    end

    // Characters at or beyond the length are zeroed.
    assign raw_text = {i_chars_high, i_chars_low};
    always_comb begin
        for (int b = 0; b < dlsr_pkg::SEG_BYTES; b++) begin
            masked_text[b*8 +: 8] = (dlsr_pkg::LEN_W'(b) < len) ? raw_text[b*8 +: 8] : 8'd0;
        end
    end

    // Command to the back end.
    always_comb begin
        o_push     = accept;
        o_cmd.slot = slot;
        o_cmd.len  = len;
        o_cmd.text = masked_text;
        o_cmd.count = count;
        if (dup) begin
            o_cmd.kind = dlsr_pkg::ST_DUPLICATE;
        end else if (complete) begin
            o_cmd.kind = dlsr_pkg::ST_EMIT;
        end else begin
            o_cmd.kind = dlsr_pkg::ST_INCOMPLETE;
        end
    end

    // Next occupancy state.
    always_comb begin
        n_present = r_present;
        n_is_last = r_is_last;
        n_toggle  = r_toggle;
        if (accept) begin
            if (dup) begin
                n_present = eff_present;
                n_is_last = eff_last;
            end else begin
                n_present = upd_present;
                n_is_last = upd_last;
                n_toggle  = toggle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_is_last <= '0;
            r_toggle  <= 1'b0;
        end else begin
            r_present <= n_present;
            r_is_last <= n_is_last;
            r_toggle  <= n_toggle;
        end
    end

endmodule

// ===== design/dlsr_queue.sv =====
// Short command queue between the front and back ends.
// Depends on dlsr_pkg.
module dlsr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dlsr_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output dlsr_pkg::t_cmd   o_cmd
);

    dlsr_pkg::t_cmd              r_entry [dlsr_pkg::QUEUE_DEPTH];
    logic [dlsr_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [dlsr_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [dlsr_pkg::QCNT_W-1:0] r_count;
    logic [dlsr_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [dlsr_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [dlsr_pkg::QCNT_W-1:0] n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full      = (r_count == dlsr_pkg::QCNT_W'(dlsr_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_entry[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    // Pointer and fill-level update; the depth is a power of two so pointers wrap.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + dlsr_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + dlsr_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + dlsr_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - dlsr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== design/dlsr_back.sv =====
// Back end: writes stored segments into the text store and drives the result
// register, one status item or one item per segment of a complete label.
// Depends on dlsr_pkg.
module dlsr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  dlsr_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic [2:0]           o_segment_index,
    output logic [4:0]           o_byte_count,
    output logic [63:0]          o_out_chars_low,
    output logic [63:0]          o_out_chars_high,
    output logic                 o_last
);

    // Segment store, no reset: a slot is read only after it was written.
    logic [dlsr_pkg::TEXT_W-1:0] r_seg_text [dlsr_pkg::SEG_SLOTS];
    logic [dlsr_pkg::LEN_W-1:0]  r_seg_len  [dlsr_pkg::SEG_SLOTS];

    dlsr_pkg::t_back_state       r_state;
    dlsr_pkg::t_back_state       n_state;
    logic [dlsr_pkg::SLOT_W-1:0] r_idx;
    logic [dlsr_pkg::SLOT_W-1:0] n_idx;
    logic [dlsr_pkg::CNT_W-1:0]  r_cnt;
    logic [dlsr_pkg::CNT_W-1:0]  n_cnt;
    logic                        r_valid;
    logic                        n_valid;

    dlsr_pkg::t_status           r_status;
    logic [2:0]                  r_index;
    logic [dlsr_pkg::LEN_W-1:0]  r_byte_count;
    logic [dlsr_pkg::TEXT_W-1:0] r_chars;
    logic                        r_last;

    logic                        out_free;
    logic                        pop;
    logic                        load_status;
    logic                        load_seg;
    logic                        seg_last;

    assign out_free = !r_valid || !i_stall;
    assign seg_last = (dlsr_pkg::CNT_W'(r_idx) + dlsr_pkg::CNT_W'(1) == r_cnt);

    // Sequencer: next state and control.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        pop         = 1'b0;
        load_status = 1'b0;
        load_seg    = 1'b0;
        unique case (r_state)
            dlsr_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == dlsr_pkg::ST_EMIT) begin
                        pop     = 1'b1;
                        n_state = dlsr_pkg::BK_EMIT;
                        n_idx   = '0;
                        n_cnt   = i_cmd.count;
                    end else if (out_free) begin
                        pop         = 1'b1;
                        load_status = 1'b1;
                    end
                end
            end
            dlsr_pkg::BK_EMIT: begin
                if (out_free) begin
                    load_seg = 1'b1;
                    if (seg_last) begin
                        n_state = dlsr_pkg::BK_IDLE;
                    end else begin
                        n_idx = r_idx + dlsr_pkg::SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = dlsr_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_cmd_pop = pop;

    // Result register occupancy.
    always_comb begin
        if (load_status || load_seg) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlsr_pkg::BK_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Store write when a non-duplicate command is taken.
    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.kind != dlsr_pkg::ST_DUPLICATE)) begin
            r_seg_text[i_cmd.slot] <= i_cmd.text;
            r_seg_len[i_cmd.slot]  <= i_cmd.len;
        end
    end

    // Result payload, loaded either with a status item or a stored segment.
    always_ff @(posedge i_clk) begin
        if (load_status) begin
            r_status     <= i_cmd.kind;
            r_index      <= 3'd0;
            r_byte_count <= '0;
            r_chars      <= '0;
            r_last       <= 1'b1;
        end else if (load_seg) begin
            r_status     <= dlsr_pkg::ST_EMIT;
            r_index      <= 3'(r_idx);
            r_byte_count <= r_seg_len[r_idx];
            r_chars      <= r_seg_text[r_idx];
            r_last       <= seg_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_segment_index  = r_index;
    assign o_byte_count     = r_byte_count;
    assign o_out_chars_low  = r_chars[63:0];
    assign o_out_chars_high = r_chars[127:64];
    assign o_last           = r_last;

endmodule

// ===== design/dynamic_label_segment_reassembler.sv =====
// Dynamic label segment reassembler, top level.
// Each input item is one checked label segment: two prefix bytes and up to
// sixteen characters in two 64-bit words. The front end decodes the prefix,
// clears the store on a toggle change, drops duplicates and out-of-range
// segment numbers, and detects when segments zero through k are present with
// the last flag at k. It queues one command per item for the back end.
// The back end stores each non-duplicate segment's text and answers with one
// status item, or, for a completed label, one item per stored segment in
// order with o_last on the final one.
// A status item passes through the command queue and the result register; a
// completed label enters the emit state, then one item per cycle unless stalled.
// Throughput is set by the back end's single store read port; while a label
// is emitted, further items wait in the command queue.
// The two-entry command queue lets the input keep accepting while results wait.
// Reset clears slot occupancy, last flags, the held toggle, the queue and the
// result register; segment text needs no reset. When i_stall is high the
// result register holds its item; the queue then fills and o_stall rises.
// Depends on dlsr_pkg, dlsr_front, dlsr_queue and dlsr_back.
module dynamic_label_segment_reassembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_prefix_first_byte,
    input  logic [7:0]  i_prefix_second_byte,
    input  logic [63:0] i_chars_low,
    input  logic [63:0] i_chars_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_segment_index,
    output logic [4:0]  o_byte_count,
    output logic [63:0] o_out_chars_low,
    output logic [63:0] o_out_chars_high,
    output logic        o_last
);

    logic           push;
    logic           queue_full;
    logic           queue_not_empty;
    logic           pop;
    dlsr_pkg::t_cmd front_cmd;
    dlsr_pkg::t_cmd back_cmd;

    // Classification of incoming segments.
    dlsr_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_prefix_first_byte  (i_prefix_first_byte),
        .i_prefix_second_byte (i_prefix_second_byte),
        .i_chars_low          (i_chars_low),
        .i_chars_high         (i_chars_high),
        .i_queue_full         (queue_full),
        .o_push               (push),
        .o_cmd                (front_cmd)
    );

    // Command buffering.
    dlsr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_cmd       (back_cmd)
    );

    // Store and result emission.
    dlsr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (queue_not_empty),
        .i_cmd            (back_cmd),
        .o_cmd_pop        (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_segment_index  (o_segment_index),
        .o_byte_count     (o_byte_count),
        .o_out_chars_low  (o_out_chars_low),
        .o_out_chars_high (o_out_chars_high),
        .o_last           (o_last)
    );

endmodule
